/* rtl/sat_pkg.sv */
// Shared types, constants and microcode program of the softmax/argmax classifier head.
`default_nettype none

package sat_pkg;

    localparam int MAX_CLASSES_DEF = 32;
    localparam int EXP_DEPTH_DEF   = 256;

    localparam int LOGIT_W   = 16;
    localparam int CONF_W    = 16;
    localparam int CLASS_W   = 5;
    localparam int EXP_W     = 17;   // table entries reach 65536
    localparam int DIV_STEPS = 17;   // quotient bits of 2^32 / sum
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // exp(-1/16) in Q0.32
    localparam logic [31:0] EXP_STEP_Q32 = 32'd4034748384;

    typedef logic [2:0] sat_step_t;

    localparam sat_step_t STEP_BUILD    = 3'd0;
    localparam sat_step_t STEP_LOAD     = 3'd1;
    localparam sat_step_t STEP_MAX      = 3'd2;
    localparam sat_step_t STEP_SUM_INIT = 3'd3;
    localparam sat_step_t STEP_SUM      = 3'd4;
    localparam sat_step_t STEP_DIV_INIT = 3'd5;
    localparam sat_step_t STEP_DIV      = 3'd6;
    localparam sat_step_t STEP_RESULT   = 3'd7;

    typedef enum logic [2:0] {
        OP_BUILD,
        OP_LOAD,
        OP_MAX,
        OP_SUM_INIT,
        OP_SUM,
        OP_DIV_INIT,
        OP_DIV,
        OP_RESULT
    } sat_op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_BUILD_LAST,
        COND_LAST_TAKEN,
        COND_SCAN_DONE,
        COND_DIV_LAST,
        COND_OUT_FREE
    } sat_cond_t;

    // Jump to target when cond holds, otherwise repeat the step.
    typedef struct packed {
        sat_op_t   op;
        sat_cond_t cond;
        sat_step_t target;
    } sat_uword_t;

    typedef struct packed {
        logic build_last;
        logic last_taken;
        logic scan_done;
        logic div_last;
        logic out_free;
    } sat_status_t;

    function automatic sat_uword_t sat_ucode(input sat_step_t step);
        sat_uword_t w;
        unique case (step)
            STEP_BUILD:    w = '{OP_BUILD,    COND_BUILD_LAST, STEP_LOAD};
            STEP_LOAD:     w = '{OP_LOAD,     COND_LAST_TAKEN, STEP_MAX};
            STEP_MAX:      w = '{OP_MAX,      COND_SCAN_DONE,  STEP_SUM_INIT};
            STEP_SUM_INIT: w = '{OP_SUM_INIT, COND_ALWAYS,     STEP_SUM};
            STEP_SUM:      w = '{OP_SUM,      COND_SCAN_DONE,  STEP_DIV_INIT};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_ALWAYS,     STEP_DIV};
            STEP_DIV:      w = '{OP_DIV,      COND_DIV_LAST,   STEP_RESULT};
            STEP_RESULT:   w = '{OP_RESULT,   COND_OUT_FREE,   STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/sat_if.sv */
// Channel interfaces: logit stream, result stream and threshold write port.
`default_nettype none

interface sat_logit_if import sat_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [LOGIT_W-1:0] logit_value;
    logic                      last_logit;

    modport source (output valid, logit_value, last_logit, input ready);
    modport sink   (input valid, logit_value, last_logit, output ready);
endinterface

interface sat_result_if import sat_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] class_index;
    logic [CONF_W-1:0]  confidence;
    logic               accepted;
    logic               overflowed;

    modport source (output valid, class_index, confidence, accepted, overflowed,
                    input ready);
    modport sink   (input valid, class_index, confidence, accepted, overflowed,
                    output ready);
endinterface

interface sat_cfg_if import sat_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CONF_W-1:0] accept_threshold;

    modport source (output valid, accept_threshold, input ready);
    modport sink   (input valid, accept_threshold, output ready);
endinterface

`default_nettype wire

/* rtl/sat_exp_table.sv */
// Exponent table memory, filled after reset by repeated Q0.32 multiplication.
`default_nettype none

module sat_exp_table import sat_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF,
    localparam int EW = $clog2(EXP_TABLE_DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          build_en,
    output logic               build_last,
    input  wire logic          rd_en,
    input  wire logic [EW-1:0] rd_addr,
    output logic [EXP_W-1:0]   rd_data
);

    logic [EXP_W-1:0] exp_mem [EXP_TABLE_DEPTH];

    logic [32:0]      p_reg, p_next;
    logic [EW-1:0]    baddr_reg, baddr_next;
    logic [63:0]      mul;
    logic [64:0]      acc;
    logic [EXP_W-1:0] entry;
    logic [EXP_W-1:0] rd_data_reg;

    // p is exactly 1.0 only on the first entry; that product is the step itself
    always_comb
    begin
        mul        = p_reg[31:0] * EXP_STEP_Q32;
        acc        = {1'b0, mul}
                   + (p_reg[32] ? {1'b0, EXP_STEP_Q32, 32'b0} : 65'd0)
                   + 65'h0_8000_0000;
        entry      = EXP_W'((p_reg + 33'h0_0000_8000) >> 16);
        p_next     = build_en ? {1'b0, acc[63:32]} : p_reg;
        baddr_next = build_en ? baddr_reg + 1'b1 : baddr_reg;
        build_last = baddr_reg == EW'(EXP_TABLE_DEPTH - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg     <= 33'h1_0000_0000;
            baddr_reg <= '0;
        end
        else
        begin
            p_reg     <= p_next;
            baddr_reg <= baddr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (build_en)
            exp_mem[baddr_reg] <= entry;
        if (rd_en)
            rd_data_reg <= exp_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/sat_sequencer.sv */
// Microcode sequencer: step counter, program lookup and jump conditions.
`default_nettype none

module sat_sequencer import sat_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sat_status_t status,
    output sat_op_t          op
);

    sat_step_t  step_reg, step_next;
    sat_uword_t uword;
    logic       hit;

    always_comb
    begin
        uword = sat_ucode(step_reg);
        unique case (uword.cond)
            COND_ALWAYS:     hit = 1'b1;
            COND_BUILD_LAST: hit = status.build_last;
            COND_LAST_TAKEN: hit = status.last_taken;
            COND_SCAN_DONE:  hit = status.scan_done;
            COND_DIV_LAST:   hit = status.div_last;
            COND_OUT_FREE:   hit = status.out_free;
            default:         hit = 1'b0;
        endcase
        step_next = hit ? uword.target : step_reg;
        op        = uword.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_BUILD;
        else
            step_reg <= step_next;
    end

endmodule

`default_nettype wire

/* rtl/sat_datapath.sv */
// Datapath: logit store, max scan, exponent sum, restoring divider, result register.
`default_nettype none

module sat_datapath import sat_pkg::*; #(
    parameter int MAX_CLASSES     = MAX_CLASSES_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF,
    localparam int EW = $clog2(EXP_TABLE_DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sat_op_t          op,
    input  wire logic             build_last,
    output sat_status_t           status,
    sat_logit_if.sink             logit,
    sat_result_if.source          result,
    sat_cfg_if.sink               cfg,
    output logic                  exp_rd_en,
    output logic [EW-1:0]         exp_rd_addr,
    input  wire logic [EXP_W-1:0] exp_rd_data
);

    localparam int CW = $clog2(MAX_CLASSES + 1);
    localparam int AW = $clog2(MAX_CLASSES);
    localparam int SW = $clog2(MAX_CLASSES) + EXP_W;

    logic [LOGIT_W-1:0] store_mem [MAX_CLASSES];

    // control state
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CONF_W-1:0] thr_reg, thr_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic              qv_reg, qv_next;
    logic              ev_reg, ev_next;
    logic              ein_reg, ein_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic signed [LOGIT_W-1:0] store_q_reg;
    logic [AW-1:0]             qidx_reg;
    logic signed [LOGIT_W-1:0] maxv_reg;
    logic [AW-1:0]             best_reg;
    logic [SW-1:0]             sum_reg;
    logic [SW-1:0]             rem_reg, rem_next;
    logic [DIV_STEPS-1:0]      quo_reg;
    logic [CLASS_W-1:0]        class_reg;
    logic [CONF_W-1:0]         conf_reg;
    logic                      acc_reg;
    logic                      ovf_out_reg;

    logic              in_take, load_wr, scanning, rd_issue, upd;
    logic [16:0]       diff;
    logic [11:0]       eidx;
    logic              inrange;
    logic [SW:0]       trial;
    logic              ge;
    logic [CONF_W-1:0] conf;
    logic              out_free, commit;

    always_comb
    begin
        in_take  = (op == OP_LOAD) && logit.valid;
        load_wr  = in_take && (count_reg < CW'(MAX_CLASSES));
        scanning = (op == OP_MAX) || (op == OP_SUM);
        rd_issue = scanning && (ptr_reg < count_reg);
        upd      = qv_reg && ((qidx_reg == '0) || (store_q_reg > maxv_reg));

        // max minus logit is never negative and fits 16 bits
        diff    = {maxv_reg[LOGIT_W-1], maxv_reg} - {store_q_reg[LOGIT_W-1], store_q_reg};
        eidx    = diff[15:4];
        inrange = {1'b0, eidx} < 13'(EXP_TABLE_DEPTH);

        trial    = {rem_reg, 1'b0};
        ge       = trial >= {1'b0, sum_reg};
        rem_next = ge ? SW'(trial - {1'b0, sum_reg}) : SW'(trial);
        conf     = quo_reg[DIV_STEPS-1] ? {CONF_W{1'b1}} : quo_reg[CONF_W-1:0];

        out_free = !out_valid_reg || result.ready;
        commit   = (op == OP_RESULT) && out_free;

        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (in_take)
        begin
            if (load_wr)
                count_next = count_reg + 1'b1;
            else
                ovf_next = 1'b1;
        end
        if (commit)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end

        unique case (op)
            OP_LOAD, OP_SUM_INIT: ptr_next = '0;
            OP_MAX, OP_SUM:       ptr_next = rd_issue ? ptr_reg + 1'b1 : ptr_reg;
            default:              ptr_next = ptr_reg;
        endcase

        qv_next  = rd_issue;
        ev_next  = (op == OP_SUM) && qv_reg;
        ein_next = inrange;

        unique case (op)
            OP_DIV_INIT: dcnt_next = '0;
            OP_DIV:      dcnt_next = dcnt_reg + 1'b1;
            default:     dcnt_next = dcnt_reg;
        endcase

        if (commit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        thr_next = cfg.valid ? cfg.accept_threshold : thr_reg;

        exp_rd_en   = (op == OP_SUM) && qv_reg && inrange;
        exp_rd_addr = eidx[EW-1:0];

        status.build_last = build_last;
        status.last_taken = in_take && logit.last_logit;
        status.scan_done  = (ptr_reg == count_reg) && !qv_reg && !ev_reg;
        status.div_last   = dcnt_reg == DCNT_W'(DIV_STEPS - 1);
        status.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            thr_reg       <= '0;
            ptr_reg       <= '0;
            qv_reg        <= 1'b0;
            ev_reg        <= 1'b0;
            ein_reg       <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            thr_reg       <= thr_next;
            ptr_reg       <= ptr_next;
            qv_reg        <= qv_next;
            ev_reg        <= ev_next;
            ein_reg       <= ein_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_wr)
            store_mem[count_reg[AW-1:0]] <= logit.logit_value;
        if (rd_issue)
        begin
            store_q_reg <= store_mem[ptr_reg[AW-1:0]];
            qidx_reg    <= ptr_reg[AW-1:0];
        end

        if ((op == OP_MAX) && upd)
        begin
            maxv_reg <= store_q_reg;
            best_reg <= qidx_reg;
        end

        if (op == OP_SUM_INIT)
            sum_reg <= '0;
        else if ((op == OP_SUM) && ev_reg && ein_reg)
            sum_reg <= sum_reg + SW'(exp_rd_data);

        // 2^32 / sum: the sum is at least 1.0, so the remainder starts at 2^32 >> 17
        if (op == OP_DIV_INIT)
        begin
            rem_reg <= SW'(32768);
            quo_reg <= '0;
        end
        else if (op == OP_DIV)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_STEPS-2:0], ge};
        end

        if (commit)
        begin
            class_reg   <= CLASS_W'(best_reg);
            conf_reg    <= conf;
            acc_reg     <= conf >= thr_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign logit.ready        = (op == OP_LOAD);
    assign cfg.ready          = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.class_index = class_reg;
    assign result.confidence  = conf_reg;
    assign result.accepted    = acc_reg;
    assign result.overflowed  = ovf_out_reg;

endmodule

`default_nettype wire

/* rtl/softmax_argmax_threshold.sv */
// Top level of the softmax/argmax classifier head with acceptance threshold.
//
// Channels: logit (sink) takes one signed Q8.8 logit per transaction, last_logit
// marks the end of a vector. result (source) gives class_index, confidence
// (Q0.16, 1/sum of exp(logit - max), saturated), accepted and overflowed once per
// vector. cfg (sink) writes accept_threshold; it is always ready.
// Logits load at one per cycle while the sequencer waits in its load step; logits
// beyond MAX_CLASSES are dropped and flagged. After the last logit of a vector the
// sequencer runs the max scan, the exponent sum (two registered memory reads in
// line), the 17-bit restoring divider and the load of the result register, then
// the result is valid. No logit of the next vector is taken until then, since the
// two serial passes over the logit store and the divider hold logit.ready low.
// After reset the exponent table is filled at one entry per cycle, with logit.ready
// low. Threshold writes are taken. A stalled result register holds; the next vector
// may load meanwhile, and the sequencer waits only when a new result is ready before
// the old one is taken.
`default_nettype none

module softmax_argmax_threshold import sat_pkg::*; #(
    parameter int MAX_CLASSES     = MAX_CLASSES_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sat_logit_if.sink    logit,
    sat_result_if.source result,
    sat_cfg_if.sink      cfg
);

    localparam int EW = $clog2(EXP_TABLE_DEPTH);

    sat_op_t          op;
    sat_status_t      status;
    logic             build_last;
    logic             exp_rd_en;
    logic [EW-1:0]    exp_rd_addr;
    logic [EXP_W-1:0] exp_rd_data;

    sat_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    sat_exp_table #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_exp (
        .clk        (clk),
        .rst_n      (rst_n),
        .build_en   (op == OP_BUILD),
        .build_last (build_last),
        .rd_en      (exp_rd_en),
        .rd_addr    (exp_rd_addr),
        .rd_data    (exp_rd_data)
    );

    sat_datapath #(
        .MAX_CLASSES     (MAX_CLASSES),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .build_last  (build_last),
        .status      (status),
        .logit       (logit),
        .result      (result),
        .cfg         (cfg),
        .exp_rd_en   (exp_rd_en),
        .exp_rd_addr (exp_rd_addr),
        .exp_rd_data (exp_rd_data)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the softmax/argmax head: directed and random logit vectors checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import sat_pkg::*;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit;
        logic                      is_last;
    } logit_beat_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_index;
        logic [CONF_W-1:0]  confidence;
        logic               accepted;
        logic               overflowed;
    } verdict_t;

    logic clk;
    logic rst_n;

    sat_logit_if  logit_ch ();
    sat_result_if result_ch ();
    sat_cfg_if    cfg_ch ();

    softmax_argmax_threshold dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .logit  (logit_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // predictor state
    logic [EXP_W-1:0]          exp_q16 [EXP_DEPTH_DEF];
    logic signed [LOGIT_W-1:0] class_scores [MAX_CLASSES_DEF];
    int                        score_count = 0;
    logic                      scores_dropped = 1'b0;
    logic [CONF_W-1:0]         threshold_reg = '0;

    verdict_t    vector_verdicts [$];
    logit_beat_t logit_backlog [$];

    int   fault_count = 0;
    logic logit_taken = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    logic [7:0] ready_mask = 8'hFF;

    // exp(-i/16) in Q0.16, stepped in Q0.32 with rounding at every step
    function automatic void build_exp_q16();
        logic [63:0] p;
        p = 64'h1_0000_0000;
        for (int i = 0; i < EXP_DEPTH_DEF; i++)
        begin
            exp_q16[i] = EXP_W'((p + 64'h8000) >> 16);
            p = (p * 64'(EXP_STEP_Q32) + 64'h8000_0000) >> 32;
        end
    endfunction

    task automatic take_logit(input logic signed [LOGIT_W-1:0] value, input logic is_last);
        verdict_t          v;
        int                peak;
        int                winner;
        int                gap;
        longint unsigned   total;
        longint unsigned   ratio;
        if (score_count < MAX_CLASSES_DEF)
        begin
            class_scores[score_count] = value;
            score_count++;
        end
        else
            scores_dropped = 1'b1;
        if (is_last)
        begin
            peak = class_scores[0];
            winner = 0;
            for (int i = 1; i < score_count; i++)
                if (int'(class_scores[i]) > peak)
                begin
                    peak = class_scores[i];
                    winner = i;
                end
            total = 0;
            for (int i = 0; i < score_count; i++)
            begin
                gap = peak - int'(class_scores[i]);
                if ((gap >> 4) < EXP_DEPTH_DEF)
                    total += exp_q16[gap >> 4];
            end
            if (total == 0)
                total = 1;
            ratio = 64'h1_0000_0000 / total;
            if (ratio > 65535)
                ratio = 65535;
            v.class_index = winner[CLASS_W-1:0];
            v.confidence  = ratio[CONF_W-1:0];
            v.accepted    = (ratio >= threshold_reg);
            v.overflowed  = scores_dropped;
            vector_verdicts = {vector_verdicts, v};
            score_count = 0;
            scores_dropped = 1'b0;
        end
    endtask

    // logit transactions feed the predictor
    always @(posedge clk)
    begin
        logit_taken <= rst_n && logit_ch.valid && logit_ch.ready;
        if (rst_n && logit_ch.valid && logit_ch.ready)
            take_logit(logit_ch.logit_value, logit_ch.last_logit);
    end

    // logit driver: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            logit_ch.valid <= 1'b0;
        else
        begin
            if (logit_taken)
                logit_backlog.delete(0);
            if (!logit_ch.valid || logit_taken)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    logit_ch.valid <= 1'b0;
                end
                else if (logit_backlog.size() != 0)
                begin
                    logit_ch.valid       <= 1'b1;
                    logit_ch.logit_value <= logit_backlog[0].logit;
                    logit_ch.last_logit  <= logit_backlog[0].is_last;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    logit_ch.valid <= 1'b0;
            end
        end
    end

    // result ready follows a random 8-bit mask indexed by stall_left, redrawn when stall_left runs out
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(0, 3))
                0: ready_mask = 8'hFF;
                1: ready_mask = 8'($urandom());
                2: ready_mask = 8'h11;
                default: ready_mask = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom());
            endcase
            stall_left = 64;
        end
        stall_left--;
        result_ch.ready <= ready_mask[stall_left[2:0]];
    end

    // result monitor
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (vector_verdicts.size() == 0)
            begin
                $error("unexpected result transaction: class_index %0d, confidence %0d",
                       result_ch.class_index, result_ch.confidence);
                fault_count++;
            end
            else
            begin
                want = vector_verdicts.pop_front();
                if (result_ch.class_index !== want.class_index)
                begin
                    $error("class_index: expected %0d, got %0d",
                           want.class_index, result_ch.class_index);
                    fault_count++;
                end
                if (result_ch.confidence !== want.confidence)
                begin
                    $error("confidence: expected %0d, got %0d",
                           want.confidence, result_ch.confidence);
                    fault_count++;
                end
                if (result_ch.accepted !== want.accepted)
                begin
                    $error("accepted: expected %0d, got %0d", want.accepted, result_ch.accepted);
                    fault_count++;
                end
                if (result_ch.overflowed !== want.overflowed)
                begin
                    $error("overflowed: expected %0d, got %0d",
                           want.overflowed, result_ch.overflowed);
                    fault_count++;
                end
            end
        end
    end

    task automatic queue_logit(input int value, input logic is_last);
        logit_beat_t b;
        if (value > 32767)
            value = 32767;
        if (value < -32768)
            value = -32768;
        b.logit = LOGIT_W'(value);
        b.is_last = is_last;
        logit_backlog = {logit_backlog, b};
    endtask

    // style 0: full-range values; 1: spread within about one table span; 2: many ties
    task automatic queue_vector(input int len, input int style);
        int base;
        int spread;
        base = int'($urandom_range(0, 65535)) - 32768;
        spread = (style == 1) ? $urandom_range(0, 4200) : $urandom_range(0, 3) * 16;
        for (int i = 0; i < len; i++)
        begin
            if (style == 0)
                queue_logit(int'($urandom_range(0, 65535)) - 32768, i == len - 1);
            else
                queue_logit(base - int'($urandom_range(0, spread)), i == len - 1);
        end
    endtask

    // idle point: all logits sent, all results back, sequencer quiet
    task automatic settle();
        while (logit_backlog.size() != 0 || vector_verdicts.size() != 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [CONF_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.accept_threshold <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        threshold_reg = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [CONF_W-1:0] phase_thresholds [6];
        int queued;
        int len;
        int pick;
        logit_ch.valid            = 1'b0;
        logit_ch.logit_value      = '0;
        logit_ch.last_logit       = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.accept_threshold   = '0;
        result_ch.ready           = 1'b0;
        rst_n                     = 1'b0;
        build_exp_q16();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed vectors; at this threshold a vector is accepted only when the
        // table entries of all logits but the winner add up to at most 1
        write_threshold(16'hFFFF);
        queue_logit(32767, 1'b1);
        queue_logit(-32768, 1'b1);
        queue_logit(-32768, 1'b0);      // difference far beyond the table
        queue_logit(32767, 1'b1);
        queue_logit(32767, 1'b0);
        queue_logit(-32768, 1'b1);
        queue_logit(5, 1'b0);           // three-way tie, lowest index wins
        queue_logit(5, 1'b0);
        queue_logit(5, 1'b1);
        queue_logit(0, 1'b0);           // last table entry and first one past it
        queue_logit(-4080, 1'b0);
        queue_logit(-4096, 1'b1);
        queue_logit(100, 1'b0);
        queue_logit(85, 1'b1);
        queue_logit(-1, 1'b0);
        queue_logit(0, 1'b1);
        settle();

        phase_thresholds = '{16'd0, 16'hFFFF, 16'h8000, 16'd1,
                             CONF_W'($urandom_range(0, 65535)),
                             CONF_W'($urandom_range(0, 65535))};
        foreach (phase_thresholds[ph])
        begin
            write_threshold(phase_thresholds[ph]);
            queued = 0;
            while (queued < 122)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    len = $urandom_range(1, 6);
                else if (pick < 17)
                    len = $urandom_range(7, MAX_CLASSES_DEF - 1);
                else if (pick < 19)
                    len = MAX_CLASSES_DEF;
                else
                    len = $urandom_range(MAX_CLASSES_DEF + 1, MAX_CLASSES_DEF + 8);
                queue_vector(len, $urandom_range(0, 2));
                queued += len;
            end
            settle();
        end

        if (fault_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/sat_pkg.sv
rtl/sat_if.sv
rtl/sat_exp_table.sv
rtl/sat_sequencer.sv
rtl/sat_datapath.sv
rtl/softmax_argmax_threshold.sv
tb/tb_top.sv
